// ===== rtl/bse_pkg.sv =====
// Package for the binary search engine: field widths, operation codes and
// default sizes. Used by bse_store and binary_search_engine; depends on nothing.
package bse_pkg;

   localparam int IDX_W           = 10;   // index fields on the request port
   localparam int KEY_W           = 32;   // value field on the request port
   localparam int COUNT_W         = 5;    // comparison count on the response port
   localparam int DEPTH_DEFAULT   = 1024;
   localparam int VALUE_W_DEFAULT = 32;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

endpackage

// ===== rtl/bse_store.sv =====
// Element store for the binary search engine: one write port, one read port
// with registered read data. Depends on bse_pkg for default sizes.
module bse_store #(
   parameter int DEPTH       = bse_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = bse_pkg::VALUE_W_DEFAULT,
   parameter int AW          = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/binary_search_engine.sv =====
// Binary search engine: element store plus a probe sequencer around one
// shared comparator. Depends on bse_pkg and bse_store.
//
// Usage:
//  - Request channel (req_*): valid/stall. A load transfer (op = load) writes
//    value into the store at write_index and produces no response. A search
//    transfer looks for value in the inclusive range lower_bound..upper_bound
//    of the store, which should hold ascending data.
//  - Response channel (rsp_*): one transfer per search with found, the
//    matching index (0 on a miss) and the number of element comparisons.
//  - A search makes a memory read and then a compare per probe, one more step
//    for the final range check after a miss and one to post the response. A
//    full 1024-entry range makes at most 11 probes, and the next item can be
//    accepted in the cycle after the response is posted.
//  - A load is written at its accepting edge; the next item can follow on the
//    next cycle. For a DEPTH that is not a power of two and is below 1024,
//    each store address is first reduced modulo DEPTH, one restoring step per
//    cycle, before the store access of each probe and load.
//  - req_stall is high while an item is in work. A finished response waits in
//    the output register while rsp_stall is high; the next item is accepted
//    meanwhile and holds only at its own posting step.
//  - Reset clears the sequencer and the response valid; store contents are
//    left undefined until written.
module binary_search_engine #(
   parameter int DEPTH       = bse_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = bse_pkg::VALUE_W_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [bse_pkg::IDX_W-1:0]        req_write_index,
   input  logic signed [bse_pkg::KEY_W-1:0] req_value,
   input  logic [bse_pkg::IDX_W-1:0]        req_lower_bound,
   input  logic [bse_pkg::IDX_W-1:0]        req_upper_bound,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [bse_pkg::IDX_W-1:0]        rsp_found_index,
   output logic [bse_pkg::COUNT_W-1:0]      rsp_comparison_count
);

   localparam int IDX_W   = bse_pkg::IDX_W;
   localparam int COUNT_W = bse_pkg::COUNT_W;
   localparam int AW      = $clog2(DEPTH);
   localparam int PW      = IDX_W + 2;          // signed bound, holds -1 and 2**IDX_W
   localparam bit NEED_RED = (DEPTH < (1 << IDX_W)) && ((DEPTH & (DEPTH - 1)) != 0);
   localparam int RED_STEPS = NEED_RED ? (IDX_W - AW + 1) : 1;
   localparam int STEP_W  = $clog2(RED_STEPS + 1);
   localparam int RW      = IDX_W + AW + 1;
   localparam logic [RW-1:0] DEPTH_R = RW'(DEPTH);
   localparam logic signed [PW-1:0] ONE = 1;
   localparam logic [COUNT_W-1:0] CNT_HIT  = 1;
   localparam logic [COUNT_W-1:0] CNT_MISS = 2;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PROBE   = 3'd1;
   localparam logic [2:0] S_COMPARE = 3'd2;
   localparam logic [2:0] S_REDUCE  = 3'd3;
   localparam logic [2:0] S_ACCESS  = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic                     is_load_ff, is_load_in;
   logic [VALUE_WIDTH-1:0]   key_ff, key_in;
   logic signed [PW-1:0]     lo_ff, lo_in;
   logic signed [PW-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic [IDX_W-1:0]         red_ff, red_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     req_xfer;
   logic                     range_empty;
   logic signed [PW-1:0]     span;
   logic signed [PW-1:0]     mid_full;
   logic signed [PW-1:0]     mid_s;
   logic [VALUE_WIDTH-1:0]   req_elem;
   logic [RW-1:0]            red_wide;
   logic [RW-1:0]            red_sub;
   logic                     slot_free;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [VALUE_WIDTH-1:0]   wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [VALUE_WIDTH-1:0]   rd_data;
   logic                     elem_eq;
   logic                     elem_gt;

   bse_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   // low VALUE_WIDTH bits of the 32-bit field; zero fill when the store is wider
   assign req_elem  = VALUE_WIDTH'($unsigned(req_value));

   assign range_empty = (hi_ff < lo_ff);
   assign span        = hi_ff - lo_ff;
   assign mid_full    = lo_ff + (span >>> 1);
   assign mid_s       = $signed({2'b00, mid_ff});

   // restoring modulo step, only used for non-power-of-two depths
   assign red_wide = RW'(red_ff);
   assign red_sub  = DEPTH_R << step_ff;

   // shared comparator
   assign elem_eq = (rd_data == key_ff);
   assign elem_gt = ($signed(rd_data) > $signed(key_ff));

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(red_ff);
      wr_data = key_ff;
      rd_en   = 1'b0;
      rd_addr = AW'(red_ff);
      if (state_ff == S_IDLE) begin
         wr_en   = req_xfer && (req_op == bse_pkg::OP_LOAD) && !NEED_RED;
         wr_addr = AW'(req_write_index);
         wr_data = req_elem;
      end else if (state_ff == S_ACCESS) begin
         wr_en = is_load_ff;
         rd_en = !is_load_ff;
      end else if (state_ff == S_PROBE) begin
         rd_en   = !range_empty && !NEED_RED;
         rd_addr = AW'(mid_full[IDX_W-1:0]);
      end
   end

   always_comb begin
      state_in   = state_ff;
      is_load_in = is_load_ff;
      key_in     = key_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      red_in     = red_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      hit_in     = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               is_load_in = (req_op == bse_pkg::OP_LOAD);
               key_in     = req_elem;
               lo_in      = $signed({2'b00, req_lower_bound});
               hi_in      = $signed({2'b00, req_upper_bound});
               red_in     = req_write_index;
               step_in    = STEP_W'(RED_STEPS - 1);
               count_in   = '0;
               hit_in     = 1'b0;
               mid_in     = '0;
               if (req_op == bse_pkg::OP_SEARCH) begin
                  state_in = S_PROBE;
               end else if (NEED_RED) begin
                  state_in = S_REDUCE;
               end
            end
         end
         S_PROBE: begin
            if (range_empty) begin
               state_in = S_FINISH;
            end else begin
               mid_in  = mid_full[IDX_W-1:0];
               red_in  = mid_full[IDX_W-1:0];
               step_in = STEP_W'(RED_STEPS - 1);
               state_in = NEED_RED ? S_REDUCE : S_COMPARE;
            end
         end
         S_REDUCE: begin
            if (red_wide >= red_sub) begin
               red_in = IDX_W'(red_wide - red_sub);
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            state_in = is_load_ff ? S_IDLE : S_COMPARE;
         end
         S_COMPARE: begin
            if (elem_eq) begin
               count_in = count_ff + CNT_HIT;
               hit_in   = 1'b1;
               state_in = S_FINISH;
            end else begin
               count_in = count_ff + CNT_MISS;
               if (elem_gt) begin
                  hi_in = mid_s - ONE;
               end else begin
                  lo_in = mid_s + ONE;
               end
               state_in = S_PROBE;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? mid_ff : '0;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_load_ff   <= is_load_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      red_ff       <= red_in;
      step_ff      <= step_in;
      count_ff     <= count_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_found_index      = rsp_index_ff;
   assign rsp_comparison_count = rsp_count_ff;

`ifndef SYNTH
   // a miss always reports index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_index == '0)
      else $error("miss reported with nonzero index");

   // hits count 2k+1 comparisons, misses 2k
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_comparison_count[0] == rsp_found)
      else $error("comparison count parity does not match found flag");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a new response is only posted from the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FINISH)
      else $error("response posted outside finish step");
`endif

endmodule
